// ===== design/epfe_pkg.sv =====
// ----------------------------------------------------------------------------
// epfe_pkg
// Shared constants, register indexes, the arctangent table and the
// controller/datapath command and status types of the flow estimator.
// ----------------------------------------------------------------------------
package epfe_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int CORDIC_STEPS  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ETA_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PT_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PT_HIGH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_GAP   = 2'd3;

  localparam logic [14:0] ETA_LIMIT_RST = 15'd9830;
  localparam logic [15:0] PT_LOW_RST    = 16'd51;
  localparam logic [15:0] PT_HIGH_RST   = 16'd2560;
  localparam logic [14:0] ETA_GAP_RST   = 15'd0;

  localparam logic signed [37:0] CORDIC_START = 38'sd326016437;
  localparam logic [16:0] THIRD_RECIP = 17'd43691;

  localparam logic [1:0] SRC_PHI  = 2'd0;
  localparam logic [1:0] SRC_GAP  = 2'd1;
  localparam logic [1:0] SRC_WALK = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       store_wr;
    logic       set_ovf;
    logic       rot_start;
    logic [1:0] rot_src;
    logic       vec_start;
    logic       add_sums;
    logic       plane_wr;
    logic       res_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       mem_rd;
    logic       acc_clr;
    logic       acc_add;
    logic       div_start;
    logic       flow_wr;
    logic       res_load;
    logic       clear_event;
    logic       harm;
    logic [1:0] sub;
  } epfe_cmd_t;

  typedef struct packed {
    logic take;
    logic full;
    logic last;
    logic cordic_done;
    logic div_done;
    logic idx_end;
    logic eta_zero;
    logic count_zero;
    logic out_busy;
  } epfe_status_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    case (idx)
      5'd0:    return 32'h20000000;
      5'd1:    return 32'h12E4051E;
      5'd2:    return 32'h09FB385B;
      5'd3:    return 32'h051111D4;
      5'd4:    return 32'h028B0D43;
      5'd5:    return 32'h0145D7E1;
      5'd6:    return 32'h00A2F61E;
      5'd7:    return 32'h00517C55;
      5'd8:    return 32'h0028BE53;
      5'd9:    return 32'h00145F2F;
      5'd10:   return 32'h000A2F98;
      5'd11:   return 32'h000517CC;
      5'd12:   return 32'h00028BE6;
      5'd13:   return 32'h000145F3;
      5'd14:   return 32'h0000A2FA;
      5'd15:   return 32'h0000517D;
      5'd16:   return 32'h000028BE;
      5'd17:   return 32'h0000145F;
      5'd18:   return 32'h00000A30;
      5'd19:   return 32'h00000518;
      5'd20:   return 32'h0000028C;
      5'd21:   return 32'h00000146;
      5'd22:   return 32'h000000A3;
      5'd23:   return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

// ===== design/epfe_if.sv =====
// ----------------------------------------------------------------------------
// epfe_if
// Particle request channel and event result channel.
// ----------------------------------------------------------------------------
interface epfe_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        momentum;
  logic signed [15:0] rapidity;
  logic [15:0]        azimuth;
  logic               last_particle;

  modport source (output valid, momentum, rapidity, azimuth, last_particle, input ready);
  modport sink (input valid, momentum, rapidity, azimuth, last_particle, output ready);
endinterface

interface epfe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] plane2_angle;
  logic signed [15:0] plane3_angle;
  logic signed [15:0] resolution2_term;
  logic signed [15:0] resolution3_term;
  logic signed [15:0] flow2_event;
  logic signed [15:0] flow3_event;
  logic [10:0]        accepted_count;
  logic               empty_event;
  logic               overflow;

  modport source (output valid, plane2_angle, plane3_angle, resolution2_term,
                  resolution3_term, flow2_event, flow3_event, accepted_count,
                  empty_event, overflow, input ready);
  modport sink (input valid, plane2_angle, plane3_angle, resolution2_term,
                resolution3_term, flow2_event, flow3_event, accepted_count,
                empty_event, overflow, output ready);
endinterface

// ===== design/epfe_cordic.sv =====
// ----------------------------------------------------------------------------
// epfe_cordic
// Shared iterative CORDIC, one micro-rotation per cycle, in rotation mode
// for sine and cosine and in vectoring mode for the arctangent.
// ----------------------------------------------------------------------------
module epfe_cordic import epfe_pkg::*; #(
  parameter int Steps = CORDIC_STEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rot_start_i,
  input  logic               vec_start_i,
  input  logic [15:0]        angle_i,
  input  logic signed [27:0] vx_i,
  input  logic signed [27:0] vy_i,
  output logic               done_o,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o,
  output logic signed [15:0] ang_o
);

  localparam int CntW = $clog2(Steps);

  logic signed [37:0] x_q, y_q, x_d, y_d, dx, dy, vx_s, vy_s;
  logic signed [33:0] z_q, z_d;
  logic [33:0]        at;
  logic [31:0]        a_rot, zr;
  logic               vec_q, flip_q, zero_q, run_q, fin_q, done_q, neg;
  logic [CntW-1:0]    cnt_q;
  logic signed [15:0] cos_q, sin_q, ang_q;

  function automatic logic signed [15:0] to_q14(input logic signed [37:0] v,
                                                input logic inv);
    logic signed [37:0] r;
    r = (v + 38'sd16384) >>> 15;
    if (inv) r = -r;
    if (r > 38'sd16384) return 16'sd16384;
    else if (r < -38'sd16384) return -16'sd16384;
    else return r[15:0];
  endfunction

  always_comb begin
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    at = {2'b00, atan_turn(5'(cnt_q))};
    neg = vec_q ? ~y_q[37] : z_q[33];
    if (neg) begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + $signed(at);
    end else begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - $signed(at);
    end
    a_rot = {angle_i, 16'h0000};
    vx_s = {{2{vx_i[27]}}, vx_i, 8'h00};
    vy_s = {{2{vy_i[27]}}, vy_i, 8'h00};
    zr = z_q[31:0] + 32'h00008000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (rot_start_i || vec_start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rot_start_i) begin
      vec_q  <= 1'b0;
      zero_q <= 1'b0;
      flip_q <= a_rot[31] ^ a_rot[30];
      x_q    <= CORDIC_START;
      y_q    <= '0;
      z_q    <= {{2{a_rot[30]}}, a_rot[30], a_rot[30:0]};
    end else if (vec_start_i) begin
      vec_q  <= 1'b1;
      flip_q <= 1'b0;
      zero_q <= (vx_i == '0) && (vy_i == '0);
      if (vx_i[27]) begin
        x_q <= -vx_s;
        y_q <= -vy_s;
        z_q <= 34'h080000000;
      end else begin
        x_q <= vx_s;
        y_q <= vy_s;
        z_q <= '0;
      end
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (fin_q) begin
      cos_q <= to_q14(x_q, flip_q);
      sin_q <= to_q14(y_q, flip_q);
      ang_q <= zero_q ? 16'sd0 : $signed(zr[31:16]);
    end
  end

  assign done_o = done_q;
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign ang_o  = ang_q;

endmodule

// ===== design/epfe_divider.sv =====
// ----------------------------------------------------------------------------
// epfe_divider
// Restoring divider, one quotient bit per cycle, for the event mean of the
// flow sums. The quotient is truncated toward zero and clamped to Q1.14.
// ----------------------------------------------------------------------------
module epfe_divider import epfe_pkg::*; #(
  parameter int NumW = 27,
  parameter int DenW = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [DenW-1:0]        den_i,
  output logic                   done_o,
  output logic signed [15:0]     quo_o
);

  localparam int CntW = $clog2(NumW);

  logic [DenW:0]      rem_q, trial;
  logic [DenW-1:0]    den_q;
  logic [NumW-1:0]    quo_q;
  logic               neg_q, run_q, fin_q, done_q, fits;
  logic [CntW-1:0]    cnt_q;
  logic signed [15:0] res_q;
  logic [15:0]        mag;

  always_comb begin
    trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
    fits  = trial >= {1'b0, den_q};
    mag   = (quo_q > NumW'(16384)) ? 16'd16384 : quo_q[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NumW-1];
      quo_q <= num_i[NumW-1] ? NumW'(-num_i) : num_i;
    end else if (run_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[NumW-2:0], fits};
    end
    if (fin_q) begin
      res_q <= neg_q ? -$signed(mag) : $signed(mag);
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

// ===== design/epfe_datapath.sv =====
// ----------------------------------------------------------------------------
// epfe_datapath
// Configuration registers, particle store, Q-vector sums, event planes,
// flow accumulator and the result register, with the shared CORDIC and
// the divider.
// ----------------------------------------------------------------------------
module epfe_datapath import epfe_pkg::*; #(
  parameter int CordicSteps  = CORDIC_STEPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  epfe_in_if.sink               in_i,
  epfe_out_if.source            out_o,
  input  epfe_cmd_t             cmd_i,
  output epfe_status_t          status_o
);

  localparam int CntW = $clog2(MAX_PARTICLES + 1);
  localparam int AdrW = $clog2(MAX_PARTICLES);
  localparam int AccW = CntW + 16;

  logic [14:0] lim_q, gap_q;
  logic [15:0] ptlo_q, pthi_q;

  logic [15:0]        pt_q, phi_q;
  logic signed [15:0] eta_q;
  logic               last_q;

  logic [CntW-1:0] count_q, idx_q;
  logic            ovf_q;
  logic [31:0]     mem_q [MAX_PARTICLES];
  logic [31:0]     rd_q;

  logic signed [27:0] qc_q [4][2];
  logic signed [27:0] qs_q [4][2];
  logic [3:0]         sel;

  logic signed [15:0] pl_q [4];
  logic signed [15:0] pp_q [2];
  logic signed [15:0] res_q [2];
  logic signed [15:0] flow_q [2];
  logic signed [AccW-1:0] acc_q;

  logic signed [16:0] eta17, gap17, lim17, half_t;
  logic [16:0]        mag17, third;
  logic [33:0]        prod;
  logic signed [15:0] plane;
  logic [15:0]        base, angle;

  logic               cor_done, div_done;
  logic signed [15:0] cor_cos, cor_sin, cor_ang, div_quo;

  logic               ov_q;
  logic signed [15:0] o_p2_q, o_p3_q, o_r2_q, o_r3_q, o_f2_q, o_f3_q;
  logic [10:0]        o_cnt_q;
  logic               o_empty_q, o_ovf_q;

  function automatic logic signed [27:0] sat_add(input logic signed [27:0] a,
                                                 input logic signed [15:0] b);
    logic signed [28:0] s;
    s = 29'(a) + 29'(b);
    if (s > 29'sd134217727) return 28'sd134217727;
    else if (s < -29'sd134217728) return -28'sd134217728;
    else return s[27:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q  <= ETA_LIMIT_RST;
      ptlo_q <= PT_LOW_RST;
      pthi_q <= PT_HIGH_RST;
      gap_q  <= ETA_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ETA_LIMIT: lim_q  <= cfg_data_i[14:0];
        CFG_PT_LOW:    ptlo_q <= cfg_data_i;
        CFG_PT_HIGH:   pthi_q <= cfg_data_i;
        CFG_ETA_GAP:   gap_q  <= cfg_data_i[14:0];
        default:       lim_q  <= lim_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      pt_q   <= in_i.momentum;
      eta_q  <= in_i.rapidity;
      phi_q  <= in_i.azimuth;
      last_q <= in_i.last_particle;
    end
  end

  always_comb begin
    eta17 = {eta_q[15], eta_q};
    gap17 = {2'b00, gap_q};
    lim17 = {2'b00, lim_q};
    sel[0] = eta17 > 17'sd0;
    sel[1] = eta17 < 17'sd0;
    sel[2] = eta17 > gap17;
    sel[3] = eta17 < -gap17;

    half_t = {cor_ang[15], cor_ang} + {16'h0000, cor_ang[15]};
    mag17  = cor_ang[15] ? 17'(-{cor_ang[15], cor_ang}) : 17'({cor_ang[15], cor_ang});
    prod   = mag17 * THIRD_RECIP;
    third  = {8'h00, prod[33:25]} << 8 | 17'(prod[24:17]);
    if (cmd_i.harm) plane = cor_ang[15] ? 16'(17'd0 - third) : third[15:0];
    else plane = half_t[16:1];

    case (cmd_i.rot_src)
      SRC_PHI:  base = phi_q;
      SRC_GAP:  base = pl_q[2] - pl_q[3];
      SRC_WALK: base = rd_q[15:0] - (rd_q[31] ? pl_q[0] : pl_q[1]);
      default:  base = phi_q;
    endcase
    angle = (base << 1) + (cmd_i.harm ? base : 16'h0000);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) mem_q[count_q[AdrW-1:0]] <= {eta_q, phi_q};
    if (cmd_i.mem_rd) rd_q <= mem_q[idx_q[AdrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      for (int s = 0; s < 4; s++) begin
        for (int h = 0; h < 2; h++) begin
          qc_q[s][h] <= '0;
          qs_q[s][h] <= '0;
        end
      end
    end else if (cmd_i.clear_event) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      for (int s = 0; s < 4; s++) begin
        for (int h = 0; h < 2; h++) begin
          qc_q[s][h] <= '0;
          qs_q[s][h] <= '0;
        end
      end
    end else begin
      if (cmd_i.store_wr) count_q <= count_q + 1'b1;
      if (cmd_i.set_ovf) ovf_q <= 1'b1;
      if (cmd_i.add_sums) begin
        for (int s = 0; s < 4; s++) begin
          if (sel[s]) begin
            qc_q[s][cmd_i.harm] <= sat_add(qc_q[s][cmd_i.harm], cor_cos);
            qs_q[s][cmd_i.harm] <= sat_add(qs_q[s][cmd_i.harm], cor_sin);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plane_wr) begin
      pl_q[cmd_i.sub] <= plane;
      if (cmd_i.sub == 2'd0) pp_q[cmd_i.harm] <= plane;
    end
    if (cmd_i.res_wr) res_q[cmd_i.harm] <= cor_cos;
    if (cmd_i.flow_wr) flow_q[cmd_i.harm] <= div_quo;
    if (cmd_i.idx_clr) idx_q <= '0;
    else if (cmd_i.idx_inc) idx_q <= idx_q + 1'b1;
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_add) acc_q <= acc_q + AccW'(cor_cos);
  end

  epfe_cordic #(.Steps(CordicSteps)) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rot_start_i (cmd_i.rot_start),
    .vec_start_i (cmd_i.vec_start),
    .angle_i     (angle),
    .vx_i        (qc_q[cmd_i.sub][cmd_i.harm]),
    .vy_i        (qs_q[cmd_i.sub][cmd_i.harm]),
    .done_o      (cor_done),
    .cos_o       (cor_cos),
    .sin_o       (cor_sin),
    .ang_o       (cor_ang)
  );

  epfe_divider #(.NumW(AccW), .DenW(CntW)) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q),
    .den_i   (count_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      o_ovf_q <= ovf_q;
      if (count_q == '0) begin
        o_p2_q    <= '0;
        o_p3_q    <= '0;
        o_r2_q    <= '0;
        o_r3_q    <= '0;
        o_f2_q    <= '0;
        o_f3_q    <= '0;
        o_cnt_q   <= '0;
        o_empty_q <= 1'b1;
      end else begin
        o_p2_q    <= pp_q[0];
        o_p3_q    <= pp_q[1];
        o_r2_q    <= res_q[0];
        o_r3_q    <= res_q[1];
        o_f2_q    <= flow_q[0];
        o_f3_q    <= flow_q[1];
        o_cnt_q   <= 11'(count_q);
        o_empty_q <= 1'b0;
      end
    end
  end

  assign out_o.valid            = ov_q;
  assign out_o.plane2_angle     = o_p2_q;
  assign out_o.plane3_angle     = o_p3_q;
  assign out_o.resolution2_term = o_r2_q;
  assign out_o.resolution3_term = o_r3_q;
  assign out_o.flow2_event      = o_f2_q;
  assign out_o.flow3_event      = o_f3_q;
  assign out_o.accepted_count   = o_cnt_q;
  assign out_o.empty_event      = o_empty_q;
  assign out_o.overflow         = o_ovf_q;

  always_comb begin
    status_o.take        = (eta17 >= -lim17) && (eta17 <= lim17) &&
                           (pt_q >= ptlo_q) && (pt_q <= pthi_q);
    status_o.full        = count_q >= CntW'(MAX_PARTICLES);
    status_o.last        = last_q;
    status_o.cordic_done = cor_done;
    status_o.div_done    = div_done;
    status_o.idx_end     = idx_q == count_q;
    status_o.eta_zero    = rd_q[31:16] == 16'h0000;
    status_o.count_zero  = count_q == '0;
    status_o.out_busy    = ov_q;
  end

endmodule

// ===== design/epfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// epfe_ctrl
// Sequencer for particle intake, plane finding, the resolution terms and
// the walk over the stored particles.
// ----------------------------------------------------------------------------
module epfe_ctrl import epfe_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  epfe_status_t status_i,
  output epfe_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EVAL   = 4'd1;
  localparam logic [3:0] S_RGO    = 4'd2;
  localparam logic [3:0] S_ROT    = 4'd3;
  localparam logic [3:0] S_NEXT   = 4'd4;
  localparam logic [3:0] S_FIN    = 4'd5;
  localparam logic [3:0] S_VSTART = 4'd6;
  localparam logic [3:0] S_VEC    = 4'd7;
  localparam logic [3:0] S_PLANE  = 4'd8;
  localparam logic [3:0] S_RSTART = 4'd9;
  localparam logic [3:0] S_RES    = 4'd10;
  localparam logic [3:0] S_RD     = 4'd11;
  localparam logic [3:0] S_CHK    = 4'd12;
  localparam logic [3:0] S_WALK   = 4'd13;
  localparam logic [3:0] S_DIV    = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  logic [3:0] state_q, state_d;
  logic       h_q, h_d;
  logic [1:0] sub_q, sub_d;

  always_comb begin
    state_d    = state_q;
    h_d        = h_q;
    sub_d      = sub_q;
    cmd_o      = '0;
    cmd_o.harm = h_q;
    cmd_o.sub  = sub_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          h_d            = 1'b0;
          state_d        = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status_i.take) begin
          state_d = S_NEXT;
        end else if (status_i.full) begin
          cmd_o.set_ovf = 1'b1;
          state_d       = S_NEXT;
        end else begin
          cmd_o.store_wr = 1'b1;
          state_d        = S_RGO;
        end
      end
      S_RGO: begin
        cmd_o.rot_start = 1'b1;
        cmd_o.rot_src   = SRC_PHI;
        state_d         = S_ROT;
      end
      S_ROT: begin
        if (status_i.cordic_done) begin
          cmd_o.add_sums = 1'b1;
          if (!h_q) begin
            h_d     = 1'b1;
            state_d = S_RGO;
          end else begin
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        state_d = status_i.last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        h_d   = 1'b0;
        sub_d = 2'd0;
        state_d = status_i.count_zero ? S_OUT : S_VSTART;
      end
      S_VSTART: begin
        cmd_o.vec_start = 1'b1;
        state_d         = S_VEC;
      end
      S_VEC: begin
        if (status_i.cordic_done) state_d = S_PLANE;
      end
      S_PLANE: begin
        cmd_o.plane_wr = 1'b1;
        if (sub_q == 2'd3) begin
          state_d = S_RSTART;
        end else begin
          sub_d   = sub_q + 2'd1;
          state_d = S_VSTART;
        end
      end
      S_RSTART: begin
        cmd_o.rot_start = 1'b1;
        cmd_o.rot_src   = SRC_GAP;
        state_d         = S_RES;
      end
      S_RES: begin
        if (status_i.cordic_done) begin
          cmd_o.res_wr  = 1'b1;
          cmd_o.idx_clr = 1'b1;
          cmd_o.acc_clr = 1'b1;
          state_d       = S_RD;
        end
      end
      S_RD: begin
        if (status_i.idx_end) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_CHK;
        end
      end
      S_CHK: begin
        if (status_i.eta_zero) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end else begin
          cmd_o.rot_start = 1'b1;
          cmd_o.rot_src   = SRC_WALK;
          state_d         = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.rot_src = SRC_WALK;
        if (status_i.cordic_done) begin
          cmd_o.acc_add = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d       = S_RD;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.flow_wr = 1'b1;
          if (!h_q) begin
            h_d     = 1'b1;
            sub_d   = 2'd0;
            state_d = S_VSTART;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.res_load    = 1'b1;
          cmd_o.clear_event = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      h_q     <= 1'b0;
      sub_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      sub_q   <= sub_d;
    end
  end

endmodule

// ===== design/event_plane_flow_estimator_core.sv =====
// ----------------------------------------------------------------------------
// event_plane_flow_estimator_core
// Event-plane flow estimator for harmonics two and three.
// ----------------------------------------------------------------------------
// Particles arrive one per request and are handled one at a time. An
// accepted particle makes two passes through the single shared CORDIC
// (second and third harmonic); a rejected particle makes none. At the last
// particle of a nonempty event the block, for each harmonic in turn, runs the
// vectoring and rotation passes for the planes and resolution term (eight
// vectoring and two rotation passes in all), walks the particle store at one
// read per stored particle and one CORDIC pass per particle of nonzero
// rapidity, and then runs the divider. The finished result waits in an output
// register, so the next event's particles are taken while it is pending.
module event_plane_flow_estimator_core import epfe_pkg::*; #(
  parameter int CordicSteps  = CORDIC_STEPS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  epfe_in_if.sink               in_i,
  epfe_out_if.source            out_o
);

  epfe_cmd_t    cmd;
  epfe_status_t status;
  logic         ready;

  epfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign in_i.ready = ready;

  epfe_datapath #(
    .CordicSteps  (CordicSteps)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

// ===== design/epfe_checker.sv =====
// ----------------------------------------------------------------------------
// epfe_checker
// Port-level checks of the event result channel.
// ----------------------------------------------------------------------------
module epfe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] res2_i,
  input logic signed [15:0] flow2_i,
  input logic signed [15:0] flow3_i,
  input logic [10:0]        count_i,
  input logic               empty_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(count_i) && $stable(flow2_i))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_i |-> count_i == 11'd0 && flow2_i == 16'sd0 && flow3_i == 16'sd0)
    else $error("empty event with nonzero fields");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !empty_i |-> count_i != 11'd0)
    else $error("event without particles not flagged empty");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> flow2_i >= -16'sd16384 && flow2_i <= 16'sd16384 &&
                    res2_i >= -16'sd16384 && res2_i <= 16'sd16384)
    else $error("cosine term out of range");

endmodule

bind event_plane_flow_estimator_core epfe_checker u_epfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .res2_i      (out_o.resolution2_term),
  .flow2_i     (out_o.flow2_event),
  .flow3_i     (out_o.flow3_event),
  .count_i     (out_o.accepted_count),
  .empty_i     (out_o.empty_event)
);

// ===== test/tb_event_plane_flow_estimator_core.sv =====
// ----------------------------------------------------------------------------
// tb_event_plane_flow_estimator_core
// Self-checking bench for the event-plane flow estimator. A directed table
// covers window edges, empty events and plane corner cases; random events
// follow under several acceptance windows, one of them overflowing the
// particle store. Both channels idle at random, and every event result is
// compared field by field against a bit-exact predictor or a table entry.
// ----------------------------------------------------------------------------
module tb_event_plane_flow_estimator_core import epfe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] r2;
    logic signed [15:0] r3;
    logic signed [15:0] f2;
    logic signed [15:0] f3;
    logic [10:0]        cnt;
    logic               emp;
    logic               ovf;
  } event_result_t;

  typedef struct packed {
    logic [15:0]   pt;
    logic [15:0]   eta;
    logic [15:0]   phi;
    logic          last;
    logic          typed;
    event_result_t res;
  } directed_row_t;

  localparam event_result_t NO_RES = '0;
  localparam event_result_t EMPTY_RES = '{0, 0, 0, 0, 0, 0, 11'd0, 1'b1, 1'b0};
  localparam event_result_t ZERO_ETA_RES = '{0, 0, 16384, 16384, 0, 0, 11'd1, 1'b0, 1'b0};

  localparam int NUM_DIRECTED = 18;
  localparam directed_row_t DIRECTED[NUM_DIRECTED] = '{
    '{16'd0, 16'd0, 16'd0, 1'b1, 1'b1, EMPTY_RES},
    '{16'd51, 16'd0, 16'd0, 1'b1, 1'b1, ZERO_ETA_RES},
    '{16'd2561, 16'd100, 16'd0, 1'b1, 1'b1, EMPTY_RES},
    '{16'd100, 16'd9831, 16'd0, 1'b1, 1'b1, EMPTY_RES},
    '{16'd51, 16'd9830, 16'd0, 1'b0, 1'b0, NO_RES},
    '{16'd2560, -16'sd9830, 16'd65535, 1'b0, 1'b0, NO_RES},
    '{16'd300, 16'd1, 16'd16384, 1'b0, 1'b0, NO_RES},
    '{16'd300, -16'sd1, 16'd32768, 1'b0, 1'b0, NO_RES},
    '{16'd65535, 16'h8000, 16'd12345, 1'b0, 1'b0, NO_RES},
    '{16'd0, 16'h7fff, 16'd0, 1'b0, 1'b0, NO_RES},
    '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 1'b0, NO_RES},
    '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, 1'b0, NO_RES},
    '{16'd500, 16'd0, 16'd40000, 1'b1, 1'b0, NO_RES},
    '{16'd200, 16'd500, 16'd16384, 1'b0, 1'b0, NO_RES},
    '{16'd200, -16'sd500, 16'd8192, 1'b0, 1'b0, NO_RES},
    '{16'd200, 16'd700, 16'd16384, 1'b1, 1'b0, NO_RES},
    '{16'd1000, 16'd4096, 16'd5000, 1'b1, 1'b0, NO_RES},
    '{16'd1000, -16'sd4096, 16'd60000, 1'b1, 1'b0, NO_RES}
  };

  localparam int NUM_PHASES = 6;
  localparam logic [15:0] PHASES[NUM_PHASES][4] = '{
    '{16'd32767, 16'd0, 16'd65535, 16'd0},
    '{16'd4096, 16'd51, 16'd2560, 16'd32767},
    '{16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd9830, 16'd65535, 16'd0, 16'd100},
    '{16'd20000, 16'd100, 16'd5000, 16'd2000},
    '{16'd12000, 16'd30, 16'd40000, 16'd800}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  epfe_in_if req_ch();
  epfe_out_if res_ch();

  event_plane_flow_estimator_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i(req_ch.sink),
    .out_o(res_ch.source)
  );

  logic [14:0] win_eta;
  logic [15:0] win_pt_lo;
  logic [15:0] win_pt_hi;
  logic [14:0] win_gap;
  longint q_sums[16];
  logic [15:0] kept_eta[$];
  logic [15:0] kept_phi[$];
  int unsigned kept_count;
  bit store_overrun;

  event_result_t pending_results[$];
  int errors;
  int cycles;
  int rx_stall;
  bit tx_quiet;
  bit rx_quiet;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void rotate(input logic [31:0] ang, output int c, output int s);
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy, cr, sr;
    a = {ang[15:0], 16'h0000};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h80000000;
    z = longint'($signed(a));
    x = 326016437;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i[4:0]));
      end
    end
    cr = (x + 16384) >>> 15;
    sr = (y + 16384) >>> 15;
    if (flip) begin
      cr = -cr; sr = -sr;
    end
    c = int'(clamp(cr, -16384, 16384));
    s = int'(clamp(sr, -16384, 16384));
  endfunction

  function automatic int cosine(input logic [31:0] ang);
    int c, s;
    rotate(ang, c, s);
    return c;
  endfunction

  function automatic int heading(input longint y, input longint x);
    logic [31:0] z, r;
    longint dx, dy;
    if (x == 0 && y == 0) return 0;
    x *= 256;
    y *= 256;
    z = 32'h0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_turn(i[4:0]);
      end else begin
        x -= dx; y += dy; z -= atan_turn(i[4:0]);
      end
    end
    r = z + 32'h8000;
    return int'($signed(r[31:16]));
  endfunction

  function automatic int plane(input int sub, input int h);
    return heading(q_sums[sub*4 + h*2 + 1], q_sums[sub*4 + h*2]) / (h + 2);
  endfunction

  function automatic void add_q(input int idx, input int v);
    q_sums[idx] = clamp(q_sums[idx] + v, -134217728, 134217727);
  endfunction

  function automatic bit predict_flow(input logic [15:0] pt, input logic [15:0] eta_raw,
                                      input logic [15:0] phi, input logic last,
                                      output event_result_t r);
    int eta, lim, gap, c, s, n, pp, pm, gp, gm;
    longint acc;
    eta = int'($signed(eta_raw));
    lim = int'(win_eta);
    gap = int'(win_gap);
    r = '0;
    if (eta >= -lim && eta <= lim && pt >= win_pt_lo && pt <= win_pt_hi) begin
      if (kept_count >= MAX_PARTICLES) begin
        store_overrun = 1'b1;
      end else begin
        kept_eta.push_back(eta_raw);
        kept_phi.push_back(phi);
        kept_count++;
        for (int h = 0; h < 2; h++) begin
          rotate((h + 2) * int'(phi), c, s);
          if (eta > 0) begin
            add_q(h*2, c); add_q(1 + h*2, s);
          end
          if (eta < 0) begin
            add_q(4 + h*2, c); add_q(5 + h*2, s);
          end
          if (eta > gap) begin
            add_q(8 + h*2, c); add_q(9 + h*2, s);
          end
          if (eta < -gap) begin
            add_q(12 + h*2, c); add_q(13 + h*2, s);
          end
        end
      end
    end
    if (!last) return 1'b0;
    if (kept_count == 0) begin
      r.emp = 1'b1;
      r.ovf = store_overrun;
    end else begin
      for (int h = 0; h < 2; h++) begin
        n = h + 2;
        pp = plane(0, h);
        pm = plane(1, h);
        gp = plane(2, h);
        gm = plane(3, h);
        acc = 0;
        for (int k = 0; k < int'(kept_count); k++) begin
          if (kept_eta[k] == 16'h0) continue;
          if (kept_eta[k][15]) acc += cosine(n * (int'(kept_phi[k]) - pp));
          else acc += cosine(n * (int'(kept_phi[k]) - pm));
        end
        acc = clamp(acc / longint'(kept_count), -16384, 16384);
        if (h == 0) begin
          r.p2 = pp[15:0]; r.r2 = 16'(cosine(n * (gp - gm))); r.f2 = acc[15:0];
        end else begin
          r.p3 = pp[15:0]; r.r3 = 16'(cosine(n * (gp - gm))); r.f3 = acc[15:0];
        end
      end
      r.cnt = kept_count[10:0];
      r.ovf = store_overrun;
    end
    q_sums = '{default: 0};
    kept_eta.delete();
    kept_phi.delete();
    kept_count = 0;
    store_overrun = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_particle(input logic [15:0] pt, input logic [15:0] eta,
                               input logic [15:0] phi, input logic last,
                               input logic typed, input event_result_t typed_res);
    int gap_cycles;
    event_result_t r;
    gap_cycles = tx_quiet ? 0 : $urandom_range(0, 8);
    repeat (gap_cycles) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.momentum <= pt;
    req_ch.rapidity <= eta;
    req_ch.azimuth <= phi;
    req_ch.last_particle <= last;
    do @(posedge clk_i); while (!req_ch.ready);
    if (predict_flow(pt, eta, phi, last, r)) pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ETA_LIMIT: win_eta = val[14:0];
      CFG_PT_LOW:    win_pt_lo = val;
      CFG_PT_HIGH:   win_pt_hi = val;
      default:       win_gap = val[14:0];
    endcase
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_event(input int len, output int sent);
    logic [15:0] pt, eta;
    int lim;
    tx_quiet = ($urandom_range(0, 3) == 0);
    lim = int'(win_eta);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        eta = 16'($urandom_range(0, 2 * lim) - lim);
        if (win_pt_lo <= win_pt_hi) pt = 16'($urandom_range(win_pt_lo, win_pt_hi));
        else pt = 16'($urandom);
        if ($urandom_range(0, 19) == 0) eta = $urandom_range(0, 1) ? 16'(lim) : 16'(-lim);
        if ($urandom_range(0, 29) == 0) eta = 16'h0;
      end else begin
        eta = 16'($urandom);
        pt = 16'($urandom);
      end
      send_particle(pt, eta, 16'($urandom), k == len - 1, 1'b0, NO_RES);
    end
    sent = len;
  endtask

  task automatic report(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, want %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    event_result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      rx_stall = rx_quiet ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) rx_quiet = !rx_quiet;
      if (pending_results.size() == 0) begin
        report("unrequested result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.plane2_angle !== want.p2) report("plane2_angle", res_ch.plane2_angle, want.p2);
        if (res_ch.plane3_angle !== want.p3) report("plane3_angle", res_ch.plane3_angle, want.p3);
        if (res_ch.resolution2_term !== want.r2)
          report("resolution2_term", res_ch.resolution2_term, want.r2);
        if (res_ch.resolution3_term !== want.r3)
          report("resolution3_term", res_ch.resolution3_term, want.r3);
        if (res_ch.flow2_event !== want.f2) report("flow2_event", res_ch.flow2_event, want.f2);
        if (res_ch.flow3_event !== want.f3) report("flow3_event", res_ch.flow3_event, want.f3);
        if (res_ch.accepted_count !== want.cnt)
          report("accepted_count", res_ch.accepted_count, want.cnt);
        if (res_ch.empty_event !== want.emp) report("empty_event", res_ch.empty_event, want.emp);
        if (res_ch.overflow !== want.ovf) report("overflow", res_ch.overflow, want.ovf);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      res_ch.ready <= 1'b0;
      rx_stall--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  initial begin
    int sent, budget;
    logic [15:0] lo, hi;
    errors = 0;
    cycles = 0;
    rx_stall = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ETA_LIMIT;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.momentum = '0;
    req_ch.rapidity = '0;
    req_ch.azimuth = '0;
    req_ch.last_particle = 1'b0;
    res_ch.ready = 1'b0;
    win_eta = ETA_LIMIT_RST;
    win_pt_lo = PT_LOW_RST;
    win_pt_hi = PT_HIGH_RST;
    win_gap = ETA_GAP_RST;
    q_sums = '{default: 0};
    kept_count = 0;
    store_overrun = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < NUM_DIRECTED; k++) begin
      send_particle(DIRECTED[k].pt, DIRECTED[k].eta, DIRECTED[k].phi, DIRECTED[k].last,
                    DIRECTED[k].typed, DIRECTED[k].res);
    end

    for (int p = 0; p < NUM_PHASES + 2; p++) begin
      wait_idle();
      if (p < NUM_PHASES) begin
        write_reg(CFG_ETA_LIMIT, PHASES[p][0]);
        write_reg(CFG_PT_LOW, PHASES[p][1]);
        write_reg(CFG_PT_HIGH, PHASES[p][2]);
        write_reg(CFG_ETA_GAP, PHASES[p][3]);
      end else begin
        lo = 16'($urandom_range(0, 3000));
        hi = 16'($urandom_range(lo, 65535));
        write_reg(CFG_ETA_LIMIT, 16'($urandom_range(0, 32767)));
        write_reg(CFG_PT_LOW, lo);
        write_reg(CFG_PT_HIGH, hi);
        write_reg(CFG_ETA_GAP, 16'($urandom_range(0, 8000)));
      end
      if (p == 0) run_event(MAX_PARTICLES + 6, sent);
      budget = 0;
      while (budget < 100) begin
        run_event($urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12),
                  sent);
        budget += sent;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
